// File: rtl/multi_button_event_detector_assert.svh
// Assertion macros shared by the checker of the button event detector.
// Each macro expects a signal named clk, and MBED_ASSERT_RST also rst_n, in the scope of its use.
`ifndef MULTI_BUTTON_EVENT_DETECTOR_ASSERT_SVH
`define MULTI_BUTTON_EVENT_DETECTOR_ASSERT_SVH

// Checked at every edge, also while reset is asserted.
`define MBED_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: lbl failed");

// Checked only outside reset.
`define MBED_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: lbl failed");

`endif

// File: rtl/mbed_pkg.sv
// Types and constants of the multi-button event detector.
// Used by every RTL module of the block; depends on nothing.
package mbed_pkg;

  localparam int MAX_BUTTONS = 8;

  localparam logic [1:0] EV_PRESSED       = 2'd0;
  localparam logic [1:0] EV_HOLD          = 2'd1;
  localparam logic [1:0] EV_HOLD_RELEASED = 2'd2;
  localparam logic [1:0] EV_RELEASED      = 2'd3;

  localparam logic CMD_SAMPLE   = 1'b0;
  localparam logic CMD_BLACKOUT = 1'b1;

  localparam logic [1:0] REG_HOLD_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_HOLD_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_TIME  = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_ms;
    logic [7:0]  button_levels;
    logic [31:0] blackout_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] button_index;
    logic [1:0] event_kind;
    logic       last_event;
  } out_item_t;

  typedef struct packed {
    logic        is_blackout;
    logic [31:0] now_ms;
    logic [7:0]  levels;
    logic [31:0] duration;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/multi_button_event_detector.sv
// Multi-button event detector: debounce, press, hold repeat and release.
// Each event of a sample is held in a pending register and enters the result queue only when
// the next event or the end of the sample comes, so the final one can be marked.
// A new sample is taken only after the last one is done; a hold check divides with the serial
// divider, or not when hold_interval is zero; a blackout or ignored sample is done on acceptance.
// Reset (synchronous, rst_n low) clears queues, button state, blackout end and loads defaults.
module multi_button_event_detector #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  mbed_pkg::in_item_t  in_data,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output mbed_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  localparam int ACTIVE = (NUM_BUTTONS < mbed_pkg::MAX_BUTTONS) ?
                          NUM_BUTTONS : mbed_pkg::MAX_BUTTONS;

  logic [15:0]         hold_threshold_r;
  logic [15:0]         hold_interval_r;
  logic [15:0]         debounce_time_r;
  logic                job_valid;
  mbed_pkg::job_t      job;
  logic                take;
  logic                ev_push;
  mbed_pkg::out_item_t ev_data;
  logic                ev_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_threshold_r <= 16'd1000;
      hold_interval_r  <= 16'd500;
      debounce_time_r  <= 16'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        mbed_pkg::REG_HOLD_THRESHOLD: hold_threshold_r <= cfg_wdata;
        mbed_pkg::REG_HOLD_INTERVAL:  hold_interval_r  <= cfg_wdata;
        mbed_pkg::REG_DEBOUNCE_TIME:  debounce_time_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mbed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .item      (in_data),
    .full      (in_full),
    .take      (take),
    .job_valid (job_valid),
    .job       (job)
  );

  mbed_back #(
    .ACTIVE (ACTIVE)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job            (job),
    .take           (take),
    .hold_threshold (hold_threshold_r),
    .hold_interval  (hold_interval_r),
    .debounce_time  (debounce_time_r),
    .ev_push        (ev_push),
    .ev_data        (ev_data),
    .ev_full        (ev_full)
  );

  mbed_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev_data),
    .full      (ev_full),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (out_data)
  );

endmodule

// File: rtl/mbed_front.sv
// Input side of the detector: a two-entry queue that takes sample and
// blackout transactions and hands them, classified, to the sweeper. Uses mbed_pkg.
module mbed_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mbed_pkg::in_item_t item,
  output logic              full,
  input  logic              take,
  output logic              job_valid,
  output mbed_pkg::job_t    job
);

  mbed_pkg::job_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_take;
  mbed_pkg::job_t new_job;

  assign full      = cnt_r == 2'd2;
  assign job_valid = cnt_r != 2'd0;
  assign job       = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_take   = take && job_valid;

  always_comb begin
    new_job.is_blackout = item.cmd == mbed_pkg::CMD_BLACKOUT;
    new_job.now_ms      = item.now_ms;
    new_job.levels      = item.button_levels;
    new_job.duration    = item.blackout_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_take) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_take};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

// File: rtl/mbed_div.sv
// Iterative 32 by 16 bit unsigned divider, one quotient bit per cycle.
// Serves the hold repeat step of the sweeper; uses mbed_pkg.
module mbed_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mbed_pkg::div_req_t req,
  output mbed_pkg::div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [15:0] rem_r;
  logic [31:0] quo_r;
  logic [15:0] dvs_r;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[31]};
  assign fits  = trial >= {1'b0, dvs_r};

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= fits ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
      quo_r <= {quo_r[30:0], fits};
    end else if (req.start) begin
      rem_r <= 16'd0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end
  end

endmodule

// File: rtl/mbed_back.sv
// Sweeper of the detector: holds the per-button state and the blackout end,
// walks the buttons of one sample and emits events. Uses mbed_pkg and mbed_div.
module mbed_back #(
  parameter int ACTIVE = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  input  mbed_pkg::job_t       job,
  output logic                 take,
  input  logic [15:0]          hold_threshold,
  input  logic [15:0]          hold_interval,
  input  logic [15:0]          debounce_time,
  output logic                 ev_push,
  output mbed_pkg::out_item_t  ev_data,
  input  logic                 ev_full
);

  localparam int IDX_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_HCMP  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]       state_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      press_time_r [ACTIVE];
  logic [ACTIVE-1:0] down_r;
  logic [31:0]      hold_count_r [ACTIVE];
  logic [31:0]      blackout_end_r;
  logic [31:0]      cur_now_r;
  logic [7:0]       cur_levels_r;
  logic [31:0]      q_r;
  logic             pend_valid_r;
  logic [2:0]       pend_idx_r;
  logic [1:0]       pend_kind_r;

  logic [31:0]        diff;
  logic               level;
  logic               down;
  logic               skip;
  logic               over_thr;
  logic               is_last;
  logic               ev_valid;
  logic [1:0]         ev_kind;
  logic               stall;
  logic               want_hold;
  mbed_pkg::div_req_t div_req;
  mbed_pkg::div_rsp_t div_rsp;

  mbed_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign diff      = cur_now_r - press_time_r[idx_r];
  assign level     = cur_levels_r[3'(idx_r)];
  assign down      = down_r[idx_r];
  assign skip      = diff < {16'd0, debounce_time};
  assign over_thr  = diff > {16'd0, hold_threshold};
  assign is_last   = idx_r == IDX_W'(ACTIVE - 1);
  assign want_hold = level && down && over_thr;
  assign take      = (state_r == ST_IDLE) && job_valid;

  always_comb begin
    ev_valid = 1'b0;
    ev_kind  = mbed_pkg::EV_PRESSED;
    if (state_r == ST_CHECK && !skip) begin
      if (level && !down) begin
        ev_valid = 1'b1;
      end else if (!level && down) begin
        ev_valid = 1'b1;
        ev_kind  = over_thr ? mbed_pkg::EV_HOLD_RELEASED : mbed_pkg::EV_RELEASED;
      end
    end else if (state_r == ST_HCMP && q_r > hold_count_r[idx_r]) begin
      ev_valid = 1'b1;
      ev_kind  = mbed_pkg::EV_HOLD;
    end
  end

  assign stall = ev_valid && pend_valid_r && ev_full;

  assign ev_push = (ev_valid && !stall && pend_valid_r) ||
                   (state_r == ST_FLUSH && pend_valid_r && !ev_full);
  assign ev_data.button_index = pend_idx_r;
  assign ev_data.event_kind   = pend_kind_r;
  assign ev_data.last_event   = state_r == ST_FLUSH;

  assign div_req.start    = state_r == ST_CHECK && !skip && want_hold &&
                            hold_interval != 16'd0;
  assign div_req.dividend = diff;
  assign div_req.divisor  = hold_interval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idx_r          <= '0;
      down_r         <= '0;
      blackout_end_r <= 32'd0;
      pend_valid_r   <= 1'b0;
      for (int b = 0; b < ACTIVE; b++) begin
        press_time_r[b] <= 32'd0;
        hold_count_r[b] <= 32'd0;
      end
    end else begin
      if (ev_valid && !stall) begin
        pend_valid_r <= 1'b1;
        pend_idx_r   <= 3'(idx_r);
        pend_kind_r  <= ev_kind;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            if (job.is_blackout) begin
              down_r         <= '0;
              blackout_end_r <= job.now_ms + job.duration;
              for (int b = 0; b < ACTIVE; b++) begin
                press_time_r[b] <= 32'd0;
                hold_count_r[b] <= 32'd0;
              end
            end else if (!(blackout_end_r > job.now_ms)) begin
              cur_now_r    <= job.now_ms;
              cur_levels_r <= job.levels;
              idx_r        <= '0;
              state_r      <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (!stall) begin
            if (!skip && want_hold) begin
              if (hold_interval == 16'd0) begin
                q_r     <= 32'hFFFF_FFFF;
                state_r <= ST_HCMP;
              end else begin
                state_r <= ST_DIV;
              end
            end else begin
              if (!skip && level && !down) begin
                press_time_r[idx_r] <= cur_now_r;
                down_r[idx_r]       <= 1'b1;
              end else if (!skip && !level && down) begin
                down_r[idx_r]       <= 1'b0;
                hold_count_r[idx_r] <= 32'd0;
              end
              if (is_last) begin
                state_r <= ST_FLUSH;
              end else begin
                idx_r <= idx_r + 1'b1;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            q_r     <= div_rsp.quotient;
            state_r <= ST_HCMP;
          end
        end
        ST_HCMP: begin
          if (!stall) begin
            if (ev_valid) begin
              hold_count_r[idx_r] <= q_r;
            end
            if (is_last) begin
              state_r <= ST_FLUSH;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_CHECK;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_r || !ev_full) begin
            pend_valid_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/mbed_out_q.sv
// Result queue of the detector: four entries between the sweeper and the
// result port. Uses mbed_pkg.
module mbed_out_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbed_pkg::out_item_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output mbed_pkg::out_item_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  mbed_pkg::out_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [PTR_W:0]      cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full    = cnt_r == (PTR_W + 1)'(DEPTH);
  assign empty   = cnt_r == '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/mbed_checker.sv
// Port-level checker of the multi-button event detector and its bind.
// Uses mbed_pkg and the macros of multi_button_event_detector_assert.svh.
`include "multi_button_event_detector_assert.svh"

module mbed_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input mbed_pkg::out_item_t out_data
);

  `MBED_ASSERT(a_empty_after_reset, !rst_n |=> out_empty)
  `MBED_ASSERT(a_room_after_reset, !rst_n |=> !in_full)
  `MBED_ASSERT_RST(a_head_holds, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
  `MBED_ASSERT_RST(a_full_needs_push, (!in_full && !in_push) |=> !in_full)

endmodule

bind multi_button_event_detector mbed_checker u_mbed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// File: bench/tb_multi_button_event_detector.sv
// Testbench for the multi-button event detector: drives samples and blackouts,
// predicts every button event and checks the result stream field by field.
// Depends on mbed_pkg and the multi_button_event_detector RTL only.
module tb_multi_button_event_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BTN = 8;
  localparam int ACTIVE_BTN = (NUM_BTN < mbed_pkg::MAX_BUTTONS) ? NUM_BTN :
                              mbed_pkg::MAX_BUTTONS;
  localparam int DRAIN_CYCLES = 6000;

  logic                rst_n;
  logic                clk;
  logic                in_push;
  mbed_pkg::in_item_t  in_data;
  logic                in_full;
  logic                out_empty;
  logic                out_pop;
  mbed_pkg::out_item_t out_data;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [15:0]         cfg_wdata;

  logic [31:0] hold_threshold_ms;
  logic [31:0] hold_interval_ms;
  logic [31:0] debounce_ms;
  logic [31:0] press_ms [mbed_pkg::MAX_BUTTONS];
  logic        btn_down [mbed_pkg::MAX_BUTTONS];
  logic [31:0] hold_steps [mbed_pkg::MAX_BUTTONS];
  logic [31:0] blackout_end_ms;

  mbed_pkg::out_item_t pending_events[$];
  mbed_pkg::out_item_t want_event;
  int                  mismatch_count;
  int                  send_idle_pct;
  int                  pop_stall_pct;

  multi_button_event_detector #(
    .NUM_BUTTONS(NUM_BTN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void clear_buttons();
    int b;
    for (b = 0; b < mbed_pkg::MAX_BUTTONS; b++) begin
      press_ms[b] = '0;
      btn_down[b] = 1'b0;
      hold_steps[b] = '0;
    end
  endfunction

  function automatic mbed_pkg::out_item_t make_event(int b, logic [1:0] kind);
    mbed_pkg::out_item_t ev;
    ev.button_index = 3'(b);
    ev.event_kind = kind;
    ev.last_event = 1'b0;
    return ev;
  endfunction

  function automatic mbed_pkg::in_item_t make_item(logic cmd, logic [31:0] now,
                                                   logic [7:0] levels, logic [31:0] dur);
    mbed_pkg::in_item_t item;
    item.cmd = cmd;
    item.now_ms = now;
    item.button_levels = levels;
    item.blackout_ms = dur;
    return item;
  endfunction

  function automatic void predict_events(mbed_pkg::in_item_t item);
    mbed_pkg::out_item_t batch [mbed_pkg::MAX_BUTTONS];
    int                  count;
    int                  b;
    logic [31:0]         diff;
    logic [31:0]         quot;
    count = 0;
    if (item.cmd == mbed_pkg::CMD_BLACKOUT) begin
      clear_buttons();
      blackout_end_ms = item.now_ms + item.blackout_ms;
      return;
    end
    if (blackout_end_ms > item.now_ms) return;
    for (b = 0; b < ACTIVE_BTN; b++) begin
      diff = item.now_ms - press_ms[b];
      if (diff < debounce_ms) continue;
      if (item.button_levels[b]) begin
        if (!btn_down[b]) begin
          press_ms[b] = item.now_ms;
          btn_down[b] = 1'b1;
          batch[count] = make_event(b, mbed_pkg::EV_PRESSED);
          count++;
        end else if (diff > hold_threshold_ms) begin
          quot = (hold_interval_ms != '0) ? diff / hold_interval_ms : '1;
          if (quot > hold_steps[b]) begin
            hold_steps[b] = quot;
            batch[count] = make_event(b, mbed_pkg::EV_HOLD);
            count++;
          end
        end
      end else if (btn_down[b]) begin
        btn_down[b] = 1'b0;
        hold_steps[b] = '0;
        batch[count] = make_event(b, (diff > hold_threshold_ms) ?
                                     mbed_pkg::EV_HOLD_RELEASED : mbed_pkg::EV_RELEASED);
        count++;
      end
    end
    if (count > 0) batch[count - 1].last_event = 1'b1;
    for (b = 0; b < count; b++) pending_events.push_back(batch[b]);
  endfunction

  // Leaves in_push high when no gap follows, so the next transaction can go out back to back.
  task automatic push_sample(mbed_pkg::in_item_t item);
    int gap;
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full);
    predict_events(item);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      mbed_pkg::REG_HOLD_THRESHOLD: hold_threshold_ms = {16'd0, value};
      mbed_pkg::REG_HOLD_INTERVAL:  hold_interval_ms = {16'd0, value};
      mbed_pkg::REG_DEBOUNCE_TIME:  debounce_ms = {16'd0, value};
      default: ;
    endcase
  endtask

  task automatic apply_config(int thr, int intv, int deb);
    quiesce();
    cfg_write(mbed_pkg::REG_HOLD_THRESHOLD, 16'(thr));
    cfg_write(mbed_pkg::REG_HOLD_INTERVAL, 16'(intv));
    cfg_write(mbed_pkg::REG_DEBOUNCE_TIME, 16'(deb));
    cfg_we <= 1'b0;
  endtask

  task automatic test_debounce_after_reset();
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd10, 8'hFF, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd50, 8'hFF, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd80, 8'h00, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1050, 8'hFF, 32'd0));
  endtask

  task automatic test_press_hold_release();
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1051, 8'h0F, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1600, 8'h0F, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1600, 8'h00, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1700, 8'hF0, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1800, 8'h00, 32'd0));
  endtask

  task automatic test_blackout();
    push_sample(make_item(mbed_pkg::CMD_BLACKOUT, 32'd2000, 8'h00, 32'd500));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd2499, 8'hFF, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd2500, 8'hFF, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_BLACKOUT, 32'd0, 8'hFF, 32'hFFFF_FFFF));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 8'hFF, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_BLACKOUT, 32'd0, 8'h00, 32'd0));
  endtask

  // The blackout end wraps past zero while the sample time does not.
  task automatic test_time_wrap();
    push_sample(make_item(mbed_pkg::CMD_BLACKOUT, 32'hFFFF_FF00, 8'h00, 32'h0000_0200));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'hFFFF_FFF0, 8'hAA, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'h0000_0050, 8'hAA, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'h0000_0400, 8'h55, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_BLACKOUT, 32'd0, 8'h00, 32'd0));
  endtask

  task automatic test_zero_interval();
    apply_config(1000, 0, 50);
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd100, 8'h01, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1200, 8'h01, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1300, 8'h01, 32'd0));
    push_sample(make_item(mbed_pkg::CMD_SAMPLE, 32'd1400, 8'h00, 32'd0));
  endtask

  task automatic test_random_traffic(int n_items, int thr, int intv, int deb,
                                     int send_idle, int pop_stall);
    int          span;
    int          i;
    int          pick;
    logic [31:0] clock_ms;
    logic [31:0] advance;
    logic [7:0]  levels;
    apply_config(thr, intv, deb);
    send_idle_pct = send_idle;
    pop_stall_pct = pop_stall;
    span = thr;
    if (deb > span) span = deb;
    if (2 * intv > span) span = 2 * intv;
    span += 16;
    clock_ms = $urandom_range(32'hF000_0000);
    levels = 8'h00;
    push_sample(make_item(mbed_pkg::CMD_BLACKOUT, clock_ms, 8'($urandom), 32'd0));
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 84) begin
        if ($urandom_range(99) < 70) advance = $urandom_range(span / 4);
        else advance = $urandom_range(2 * span);
        clock_ms += advance;
        levels ^= 8'($urandom & $urandom);
        push_sample(make_item(mbed_pkg::CMD_SAMPLE, clock_ms, levels, $urandom));
      end else if (pick < 90) begin
        push_sample(make_item(mbed_pkg::CMD_BLACKOUT, clock_ms, 8'($urandom),
                              $urandom_range(span)));
      end else if (pick < 95) begin
        push_sample(make_item(mbed_pkg::CMD_SAMPLE, $urandom, 8'($urandom), $urandom));
      end else begin
        push_sample(make_item(mbed_pkg::CMD_BLACKOUT, $urandom, 8'($urandom), $urandom));
        push_sample(make_item(mbed_pkg::CMD_BLACKOUT, clock_ms, 8'($urandom), 32'd0));
      end
    end
  endtask

  always @(posedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event button %0d kind %0d last %0d",
                                  out_data.button_index, out_data.event_kind,
                                  out_data.last_event));
      end else begin
        want_event = pending_events.pop_front();
        if (out_data.button_index !== want_event.button_index)
          report_mismatch($sformatf("button_index %0d, expected %0d",
                                    out_data.button_index, want_event.button_index));
        if (out_data.event_kind !== want_event.event_kind)
          report_mismatch($sformatf("event_kind %0d, expected %0d on button %0d",
                                    out_data.event_kind, want_event.event_kind,
                                    want_event.button_index));
        if (out_data.last_event !== want_event.last_event)
          report_mismatch($sformatf("last_event %0d, expected %0d on button %0d",
                                    out_data.last_event, want_event.last_event,
                                    want_event.button_index));
      end
    end
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatch_count = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_threshold_ms = 32'd1000;
    hold_interval_ms = 32'd500;
    debounce_ms = 32'd50;
    blackout_end_ms = '0;
    clear_buttons();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_debounce_after_reset();
    test_press_hold_release();
    test_blackout();
    test_time_wrap();
    test_zero_interval();
    test_random_traffic(75, 300, 100, 20, 0, 0);
    test_random_traffic(75, 0, 1, 0, 80, 0);
    test_random_traffic(65, 65535, 65535, 65535, 0, 80);
    test_random_traffic(75, 2000, 700, 0, 32, 32);

    quiesce();
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d events never delivered", pending_events.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
